FILE: rtl/assert_macros.svh
// assertion macros shared by the checker files
// expects signals named clock and reset in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vcdc checker: assertion failed");

// next-cycle implication
`define VC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vcdc checker: assertion failed");

`endif

FILE: rtl/vcdc_pkg.sv
// shared widths, codes and types of the dotted-circle inserter
// no dependencies
`default_nettype none
package vcdc_pkg;
   localparam int GLYPH_W     = 16;
   localparam int CP_W        = 21;
   localparam int CLUSTER_W   = 32;
   localparam int SCRIPT_W    = 32;
   localparam int REC_IDX_W   = 7;
   localparam int COUNT_W     = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int TABLE_DEPTH = 128;
   localparam int TBL_IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int TBL_CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int REC_W       = SCRIPT_W + 3 * CP_W;

   localparam logic [CP_W-1:0] DC_CODE_POINT = CP_W'(32'h25CC);

   localparam logic [CSR_IDX_W-1:0] CSR_SCRIPT_TAG   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DC_GLYPH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_COUNT = 2'd2;

   typedef struct packed {
      logic [SCRIPT_W-1:0] script_tag;
      logic [GLYPH_W-1:0]  dc_glyph;
      logic [COUNT_W-1:0]  rec_count;
   } cfg_type;

   typedef struct packed {
      logic [SCRIPT_W-1:0] script;
      logic [CP_W-1:0]     first;
      logic [CP_W-1:0]     second;
      logic [CP_W-1:0]     third;
   } record_type;

   typedef struct packed {
      logic                 is_record;
      logic                 rec_ok;
      logic [TBL_IDX_W-1:0] rec_addr;
      record_type           rec;
      logic [GLYPH_W-1:0]   glyph_id;
      logic [CP_W-1:0]      glyph_cp;
      logic [CLUSTER_W-1:0] cluster;
      logic                 last_glyph;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

   typedef struct packed {
      logic [GLYPH_W-1:0]   out_glyph_id;
      logic [CP_W-1:0]      out_code_point;
      logic [CLUSTER_W-1:0] out_cluster;
      logic                 was_inserted;
      logic                 end_of_text;
      logic                 last_of_burst;
   } rsp_type;
endpackage
`default_nettype wire

FILE: rtl/vcdc_if.sv
// request, response and csr channel interfaces
// depends on vcdc_pkg
`default_nettype none
interface vcdc_req_if;
   logic                            valid;
   logic                            ready;
   logic                            action;
   logic [vcdc_pkg::GLYPH_W-1:0]    glyph_id;
   logic [vcdc_pkg::CP_W-1:0]       glyph_cp;
   logic [vcdc_pkg::CLUSTER_W-1:0]  cluster;
   logic                            last_glyph;
   logic [vcdc_pkg::REC_IDX_W-1:0]  record_index;
   logic [vcdc_pkg::SCRIPT_W-1:0]   record_script;
   logic [vcdc_pkg::CP_W-1:0]       record_first;
   logic [vcdc_pkg::CP_W-1:0]       record_second;
   logic [vcdc_pkg::CP_W-1:0]       record_third;
   modport source (output valid, action, glyph_id, glyph_cp, cluster, last_glyph,
                   record_index, record_script, record_first, record_second,
                   record_third, input ready);
   modport sink (input valid, action, glyph_id, glyph_cp, cluster, last_glyph,
                 record_index, record_script, record_first, record_second,
                 record_third, output ready);
endinterface

interface vcdc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [vcdc_pkg::GLYPH_W-1:0]    out_glyph_id;
   logic [vcdc_pkg::CP_W-1:0]       out_code_point;
   logic [vcdc_pkg::CLUSTER_W-1:0]  out_cluster;
   logic                            was_inserted;
   logic                            end_of_text;
   logic                            last_of_burst;
   modport source (output valid, out_glyph_id, out_code_point, out_cluster,
                   was_inserted, end_of_text, last_of_burst, input ready);
   modport sink (input valid, out_glyph_id, out_code_point, out_cluster,
                 was_inserted, end_of_text, last_of_burst, output ready);
endinterface

interface vcdc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [vcdc_pkg::CSR_IDX_W-1:0]  index;
   logic [vcdc_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/vcdc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module vcdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                           wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

FILE: rtl/vcdc_front.sv
// front end: accepts requests, classifies them and queues them two deep
// depends on vcdc_pkg and vcdc_if
`default_nettype none
module vcdc_front (
   input  wire logic          clock,
   input  wire logic          reset,
   vcdc_req_if.sink           req_ch,
   input  wire logic          pop,
   output vcdc_pkg::queue_type q_out
);
   vcdc_pkg::item_type q_ff [2];
   logic               wptr_ff, wptr_in;
   logic               rptr_ff, rptr_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               push, do_pop;
   vcdc_pkg::item_type item;

   always_comb begin
      item.is_record  = req_ch.action;
      item.rec_ok     = 32'(req_ch.record_index) < 32'(vcdc_pkg::TABLE_DEPTH);
      item.rec_addr   = vcdc_pkg::TBL_IDX_W'(req_ch.record_index);
      item.rec.script = req_ch.record_script;
      item.rec.first  = req_ch.record_first;
      item.rec.second = req_ch.record_second;
      item.rec.third  = req_ch.record_third;
      item.glyph_id   = req_ch.glyph_id;
      item.glyph_cp   = req_ch.glyph_cp;
      item.cluster    = req_ch.cluster;
      item.last_glyph = req_ch.last_glyph;
   end

   assign req_ch.ready = (cnt_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign do_pop       = pop && (cnt_ff != 2'd0);
   assign wptr_in      = push ? ~wptr_ff : wptr_ff;
   assign rptr_in      = do_pop ? ~rptr_ff : rptr_ff;
   assign cnt_in       = cnt_ff + {1'b0, push} - {1'b0, do_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= item;
      end
   end

   assign q_out.valid = (cnt_ff != 2'd0);
   assign q_out.item  = q_ff[rptr_ff];
endmodule
`default_nettype wire

FILE: rtl/vcdc_back.sv
// back end: record table, glyph window, table scan and result emission
// depends on vcdc_pkg and vcdc_ram
`default_nettype none
module vcdc_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire vcdc_pkg::cfg_type cfg,
   input  wire vcdc_pkg::queue_type q_in,
   output logic                 pop,
   input  wire logic            rsp_ready,
   output logic                 rsp_valid,
   output vcdc_pkg::rsp_type    rsp
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]                         state_ff, state_in;
   logic [vcdc_pkg::GLYPH_W-1:0]       wg_ff [3], wg_in [3];
   logic [vcdc_pkg::CP_W-1:0]          wp_ff [3], wp_in [3];
   logic [vcdc_pkg::CLUSTER_W-1:0]     wc_ff [3], wc_in [3];
   logic [1:0]                         n_ff, n_in;
   logic                               last_ff, last_in;
   logic [vcdc_pkg::TBL_CNT_W-1:0]     idx_ff, idx_in;
   logic [1:0]                         len_ff, len_in;
   logic [1:0]                         j_ff, j_in;
   logic                               rv_ff, rv_in;
   vcdc_pkg::rsp_type                  rsp_ff, rsp_in;

   logic [vcdc_pkg::TBL_CNT_W-1:0]     eff;
   logic [vcdc_pkg::REC_W-1:0]         rdata;
   vcdc_pkg::record_type               rec;
   logic                               we, hit, work, out_free, grp_last, burst_last;
   logic [vcdc_pkg::CP_W-1:0]          c3;
   logic [1:0]                         drop, nnext, cnt_last;
   vcdc_pkg::rsp_type                  item;

   assign eff = (32'(cfg.rec_count) < 32'(vcdc_pkg::TABLE_DEPTH))
                ? vcdc_pkg::TBL_CNT_W'(cfg.rec_count)
                : vcdc_pkg::TBL_CNT_W'(vcdc_pkg::TABLE_DEPTH);

   assign we = (state_ff == S_IDLE) && q_in.valid && q_in.item.is_record && q_in.item.rec_ok;

   vcdc_ram #(
      .WIDTH(vcdc_pkg::REC_W),
      .DEPTH(vcdc_pkg::TABLE_DEPTH)
   ) u_table (
      .clock(clock),
      .we   (we),
      .waddr(q_in.item.rec_addr),
      .wdata(q_in.item.rec),
      .raddr(idx_ff[vcdc_pkg::TBL_IDX_W-1:0]),
      .rdata(rdata)
   );

   assign rec      = vcdc_pkg::record_type'(rdata);
   assign c3       = (n_ff == 2'd3) ? wp_ff[2] : '0;
   assign hit      = (rec.script == cfg.script_tag) && (rec.first == wp_ff[0])
                     && (rec.second == wp_ff[1]);
   assign work     = (n_ff == 2'd3) || (last_ff && (n_ff == 2'd2));
   assign out_free = !rv_ff || rsp_ready;
   assign drop     = (len_ff == 2'd0) ? 2'd1 : len_ff;
   assign nnext    = n_ff - drop;
   assign cnt_last = len_ff;
   assign grp_last = (j_ff == cnt_last);
   assign burst_last = grp_last && !(last_ff && (nnext != 2'd0));

   always_comb begin
      item.out_glyph_id   = wg_ff[0];
      item.out_code_point = wp_ff[0];
      item.out_cluster    = wc_ff[0];
      item.was_inserted   = 1'b0;
      case ({len_ff, j_ff})
         4'b10_01, 4'b11_10: begin
            item.out_glyph_id   = cfg.dc_glyph;
            item.out_code_point = vcdc_pkg::DC_CODE_POINT;
            item.out_cluster    = (len_ff == 2'd2) ? wc_ff[1] : wc_ff[2];
            item.was_inserted   = 1'b1;
         end
         4'b10_10, 4'b11_01: begin
            item.out_glyph_id   = wg_ff[1];
            item.out_code_point = wp_ff[1];
            item.out_cluster    = wc_ff[1];
         end
         4'b11_11: begin
            item.out_glyph_id   = wg_ff[2];
            item.out_code_point = wp_ff[2];
            item.out_cluster    = wc_ff[2];
         end
         default: begin
         end
      endcase
      item.last_of_burst = burst_last;
      item.end_of_text   = burst_last && last_ff;
   end

   always_comb begin
      state_in = state_ff;
      wg_in    = wg_ff;
      wp_in    = wp_ff;
      wc_in    = wc_ff;
      n_in     = n_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      j_in     = j_ff;
      rv_in    = rv_ff && !rsp_ready;
      rsp_in   = rsp_ff;
      pop      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_in.valid) begin
               pop = 1'b1;
               if (!q_in.item.is_record) begin
                  wg_in[n_ff] = q_in.item.glyph_id;
                  wp_in[n_ff] = q_in.item.glyph_cp;
                  wc_in[n_ff] = q_in.item.cluster;
                  n_in        = n_ff + 2'd1;
                  last_in     = q_in.item.last_glyph;
                  state_in    = S_EVAL;
               end
            end
         end
         S_EVAL: begin
            j_in = 2'd0;
            if (work && (eff != '0)) begin
               idx_in   = '0;
               state_in = S_READ;
            end else if (work || (last_ff && (n_ff == 2'd1))) begin
               len_in   = 2'd0;
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (hit && (rec.third == '0)) begin
               len_in   = 2'd2;
               state_in = S_EMIT;
            end else if (hit && (rec.third == c3)) begin
               len_in   = 2'd3;
               state_in = S_EMIT;
            end else if ((idx_ff + vcdc_pkg::TBL_CNT_W'(1)) == eff) begin
               len_in   = 2'd0;
               state_in = S_EMIT;
            end else begin
               idx_in   = idx_ff + vcdc_pkg::TBL_CNT_W'(1);
               state_in = S_READ;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rv_in  = 1'b1;
               rsp_in = item;
               if (grp_last) begin
                  case (drop)
                     2'd1: begin
                        wg_in[0] = wg_ff[1]; wp_in[0] = wp_ff[1]; wc_in[0] = wc_ff[1];
                        wg_in[1] = wg_ff[2]; wp_in[1] = wp_ff[2]; wc_in[1] = wc_ff[2];
                     end
                     2'd2: begin
                        wg_in[0] = wg_ff[2]; wp_in[0] = wp_ff[2]; wc_in[0] = wc_ff[2];
                     end
                     default: begin
                     end
                  endcase
                  n_in     = nnext;
                  state_in = S_EVAL;
               end else begin
                  j_in = j_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff     <= 2'd0;
         last_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         last_ff  <= last_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      wg_ff  <= wg_in;
      wp_ff  <= wp_in;
      wc_ff  <= wc_in;
      idx_ff <= idx_in;
      len_ff <= len_in;
      j_ff   <= j_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp       = rsp_ff;
endmodule
`default_nettype wire

FILE: rtl/vowel_constraint_dotted_circle_insert.sv
// top level of the vowel-constraint dotted-circle inserter
// depends on vcdc_pkg, vcdc_if, vcdc_front and vcdc_back
//
// channel   dir   transfer when         carries
// req_ch    in    valid && ready        record write or one glyph of a run
// rsp_ch    out   valid && ready        one emitted glyph
// csr_ch    in    valid && ready        register index and data
//
// a glyph is taken in S_IDLE and its window evaluated in S_EVAL; each evaluation that emits
// scans the table record by record up to the first hit or the table end (at most
// min(record_count, 128) records), emits each result and re-evaluates the window; a record
// write is done from S_IDLE; the table has one registered read port, so each record scanned
// passes S_READ, then S_CMP; reset is synchronous and clears control state and the csr registers
// a two-entry request queue keeps accepting, until it is full, while results wait on rsp_ch
`default_nettype none
module vowel_constraint_dotted_circle_insert (
   input wire logic   clock,
   input wire logic   reset,
   vcdc_req_if.sink   req_ch,
   vcdc_rsp_if.source rsp_ch,
   vcdc_csr_if.sink   csr_ch
);
   vcdc_pkg::cfg_type   cfg_ff, cfg_in;
   vcdc_pkg::queue_type q;
   vcdc_pkg::rsp_type   rsp;
   logic                pop;
   logic                rsp_valid;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            vcdc_pkg::CSR_SCRIPT_TAG:   cfg_in.script_tag = csr_ch.data;
            vcdc_pkg::CSR_DC_GLYPH:     cfg_in.dc_glyph = csr_ch.data[vcdc_pkg::GLYPH_W-1:0];
            vcdc_pkg::CSR_RECORD_COUNT: cfg_in.rec_count = csr_ch.data[vcdc_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vcdc_front u_front (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .pop   (pop),
      .q_out (q)
   );

   vcdc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_in     (q),
      .pop      (pop),
      .rsp_ready(rsp_ch.ready),
      .rsp_valid(rsp_valid),
      .rsp      (rsp)
   );

   assign rsp_ch.valid          = rsp_valid;
   assign rsp_ch.out_glyph_id   = rsp.out_glyph_id;
   assign rsp_ch.out_code_point = rsp.out_code_point;
   assign rsp_ch.out_cluster    = rsp.out_cluster;
   assign rsp_ch.was_inserted   = rsp.was_inserted;
   assign rsp_ch.end_of_text    = rsp.end_of_text;
   assign rsp_ch.last_of_burst  = rsp.last_of_burst;
endmodule
`default_nettype wire

FILE: rtl/vcdc_checker.sv
// port-level checker for the dotted-circle inserter, bound to the top level
// depends on vcdc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module vcdc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [vcdc_pkg::GLYPH_W-1:0]   out_glyph_id,
   input wire logic [vcdc_pkg::CP_W-1:0]      out_code_point,
   input wire logic [vcdc_pkg::CLUSTER_W-1:0] out_cluster,
   input wire logic                           was_inserted,
   input wire logic                           end_of_text,
   input wire logic                           last_of_burst
);
   // stalled response holds
   `VC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(out_cluster) && $stable(out_glyph_id))
   // end of run closes a burst
   `VC_ASSERT_NOW(a_eot_burst, rsp_valid && end_of_text, last_of_burst)
   // inserted glyph carries the dotted circle code point
   `VC_ASSERT_NOW(a_ins_cp, rsp_valid && was_inserted, out_code_point == vcdc_pkg::DC_CODE_POINT)
   // an inserted glyph never closes its burst; the matched glyph follows it
   `VC_ASSERT_NOW(a_ins_not_last, rsp_valid && was_inserted, !last_of_burst)
endmodule

bind vowel_constraint_dotted_circle_insert vcdc_checker u_vcdc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .out_glyph_id  (rsp_ch.out_glyph_id),
   .out_code_point(rsp_ch.out_code_point),
   .out_cluster   (rsp_ch.out_cluster),
   .was_inserted  (rsp_ch.was_inserted),
   .end_of_text   (rsp_ch.end_of_text),
   .last_of_burst (rsp_ch.last_of_burst)
);
`default_nettype wire
